// File: sv/timq_pkg.sv
// timq_pkg: shared types and constants for the thresholded indexed min queue.
// No dependencies.
package timq_pkg;

    localparam int KEY_W   = 32;
    localparam int INDEX_W = 10;
    localparam int AMT_W   = 11;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SIZE   = 2'd2,
        OP_CLEAR  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_GROW,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

// File: sv/timq_ram.sv
// timq_ram: generic simple dual-port RAM with registered read.
// No dependencies.
module timq_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/thresholded_indexed_min_queue_core.sv
// An accepted request passes through ST_COPY_RD and ST_COPY_WR per moved entry on remove,
// ST_GROW per new entry on a growing set size, then ST_SCAN and ST_DONE; one request
// at a time, bounded by the single read port of the entry RAM, which the front scan
// walks one entry per cycle.
// Reset: live size and max_error clear to zero, no result pending; no clearing pass.
// thresholded_indexed_min_queue_core: top level. Uses timq_pkg and timq_ram.
module thresholded_indexed_min_queue_core #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [timq_pkg::KEY_W-1:0]   cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   opcode,
    input  logic [timq_pkg::INDEX_W-1:0] index,
    input  logic [timq_pkg::KEY_W-1:0]   error_value,
    input  logic [timq_pkg::AMT_W-1:0]   amount,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [timq_pkg::INDEX_W-1:0] front_index,
    output logic                         front_valid,
    output logic [timq_pkg::AMT_W-1:0]   queue_count,
    output logic                         status
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int SW = (CW > 12) ? CW : 12;
    localparam int DW = timq_pkg::KEY_W + 1;

    timq_pkg::state_t state_reg, state_next;

    logic [timq_pkg::KEY_W-1:0] max_error_reg;
    logic [CW-1:0] live_reg, live_next;
    logic [CW-1:0] src_reg, src_next;
    logic [CW-1:0] dst_reg, dst_next;
    logic [CW-1:0] stop_reg, stop_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] pend_idx_reg, pend_idx_next;
    logic [CW-1:0] count_reg, count_next;
    logic          found_reg, found_next;
    logic [AW-1:0] best_reg, best_next;
    logic [timq_pkg::KEY_W-1:0] best_key_reg, best_key_next;
    logic          status_reg, status_next;

    logic                         out_valid_reg, out_valid_next;
    logic [timq_pkg::INDEX_W-1:0] front_index_reg, front_index_next;
    logic                         front_valid_reg, front_valid_next;
    logic [timq_pkg::AMT_W-1:0]   queue_count_reg, queue_count_next;
    logic                         out_status_reg, out_status_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [DW-1:0] ram_wdata, ram_rdata;

    logic [SW-1:0] idx_w, amt_w, live_w, end_w, new_size_w, gap_end_w, src_base_w;
    logic [SW-1:0] best_w, count_w;
    logic [timq_pkg::KEY_W-1:0] rd_key;
    logic          rd_placed;

    timq_ram #(
        .WIDTH(DW),
        .DEPTH(MAX_ENTRIES)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_placed = ram_rdata[DW-1];
    assign rd_key    = ram_rdata[timq_pkg::KEY_W-1:0];

    always_comb
    begin
        idx_w      = SW'(index);
        amt_w      = SW'(amount);
        live_w     = SW'(live_reg);
        end_w      = idx_w + amt_w;
        new_size_w = live_w - amt_w;
        gap_end_w  = (end_w <= new_size_w) ? end_w : new_size_w;
        src_base_w = (end_w <= new_size_w) ? new_size_w : end_w;
        best_w     = SW'(best_reg);
        count_w    = SW'(count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_error_reg <= '0;
        end
        else if (cfg_we)
        begin
            max_error_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= timq_pkg::ST_IDLE;
            live_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            live_reg      <= live_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg         <= src_next;
        dst_reg         <= dst_next;
        stop_reg        <= stop_next;
        scan_reg        <= scan_next;
        pend_idx_reg    <= pend_idx_next;
        count_reg       <= count_next;
        found_reg       <= found_next;
        best_reg        <= best_next;
        best_key_reg    <= best_key_next;
        status_reg      <= status_next;
        front_index_reg <= front_index_next;
        front_valid_reg <= front_valid_next;
        queue_count_reg <= queue_count_next;
        out_status_reg  <= out_status_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        live_next        = live_reg;
        src_next         = src_reg;
        dst_next         = dst_reg;
        stop_next        = stop_reg;
        scan_next        = scan_reg;
        pend_next        = 1'b0;
        pend_idx_next    = pend_idx_reg;
        count_next       = count_reg;
        found_next       = found_reg;
        best_next        = best_reg;
        best_key_next    = best_key_reg;
        status_next      = status_reg;
        out_valid_next   = out_valid_reg && out_stall;
        front_index_next = front_index_reg;
        front_valid_next = front_valid_reg;
        queue_count_next = queue_count_reg;
        out_status_next  = out_status_reg;
        ram_we           = 1'b0;
        ram_waddr        = dst_reg[AW-1:0];
        ram_wdata        = '0;
        ram_raddr        = src_reg[AW-1:0];

        case (state_reg)
            timq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    status_next = 1'b0;
                    scan_next   = '0;
                    count_next  = '0;
                    found_next  = 1'b0;
                    best_next   = '0;
                    state_next  = timq_pkg::ST_SCAN;
                    case (timq_pkg::opcode_t'(opcode))
                        timq_pkg::OP_WRITE:
                        begin
                            if (idx_w < live_w)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = idx_w[AW-1:0];
                                ram_wdata = {1'b1, error_value};
                            end
                            else
                            begin
                                status_next = 1'b1;
                            end
                        end
                        timq_pkg::OP_REMOVE:
                        begin
                            if (end_w <= live_w)
                            begin
                                live_next = new_size_w[CW-1:0];
                                src_next  = src_base_w[CW-1:0];
                                dst_next  = idx_w[CW-1:0];
                                stop_next = gap_end_w[CW-1:0];
                                if (idx_w < gap_end_w)
                                begin
                                    state_next = timq_pkg::ST_COPY_RD;
                                end
                            end
                            else
                            begin
                                status_next = 1'b1;
                            end
                        end
                        timq_pkg::OP_SIZE:
                        begin
                            if (amt_w <= SW'(MAX_ENTRIES))
                            begin
                                live_next = amt_w[CW-1:0];
                                dst_next  = live_reg;
                                stop_next = amt_w[CW-1:0];
                                if (amt_w > live_w)
                                begin
                                    state_next = timq_pkg::ST_GROW;
                                end
                            end
                            else
                            begin
                                status_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            live_next = '0;
                        end
                    endcase
                end
            end
            timq_pkg::ST_COPY_RD:
            begin
                ram_raddr  = src_reg[AW-1:0];
                state_next = timq_pkg::ST_COPY_WR;
            end
            timq_pkg::ST_COPY_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = dst_reg[AW-1:0];
                ram_wdata = ram_rdata;
                src_next  = src_reg + 1'b1;
                dst_next  = dst_reg + 1'b1;
                if (dst_reg + 1'b1 == stop_reg)
                begin
                    state_next = timq_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = timq_pkg::ST_COPY_RD;
                end
            end
            timq_pkg::ST_GROW:
            begin
                ram_we    = 1'b1;
                ram_waddr = dst_reg[AW-1:0];
                ram_wdata = '0;
                dst_next  = dst_reg + 1'b1;
                if (dst_reg + 1'b1 == stop_reg)
                begin
                    state_next = timq_pkg::ST_SCAN;
                end
            end
            timq_pkg::ST_SCAN:
            begin
                ram_raddr = scan_reg[AW-1:0];
                if (scan_reg < live_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg[AW-1:0];
                    scan_next     = scan_reg + 1'b1;
                end
                if (pend_reg && rd_placed && (rd_key <= max_error_reg))
                begin
                    count_next = count_reg + 1'b1;
                    if (!found_reg || (rd_key < best_key_reg))
                    begin
                        found_next    = 1'b1;
                        best_next     = pend_idx_reg;
                        best_key_next = rd_key;
                    end
                end
                if ((scan_reg == live_reg) && !pend_reg)
                begin
                    state_next = timq_pkg::ST_DONE;
                end
            end
            timq_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    front_index_next = found_reg ? best_w[timq_pkg::INDEX_W-1:0] : '0;
                    front_valid_next = found_reg;
                    queue_count_next = count_w[timq_pkg::AMT_W-1:0];
                    out_status_next  = status_reg;
                    state_next       = timq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = timq_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_stall    = (state_reg != timq_pkg::ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign front_index = front_index_reg;
    assign front_valid = front_valid_reg;
    assign queue_count = queue_count_reg;
    assign status      = out_status_reg;

endmodule
